// ===== sv/tlrp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlrp_pkg: shared definitions for the telnet receive line parser
// Telnet command bytes, line control characters and the result record
// passed from the byte parser to the output pipeline.
// ----------------------------------------------------------------------------
package tlrp_pkg;

  localparam int LINE_CAPACITY_DEF = 256;

  localparam logic [7:0] B_IAC   = 8'd255;
  localparam logic [7:0] B_SB    = 8'd250;
  localparam logic [7:0] B_SE    = 8'd240;
  localparam logic [7:0] B_WILL  = 8'd251;
  localparam logic [7:0] B_DONT  = 8'd254;
  localparam logic [7:0] B_CR    = 8'd13;
  localparam logic [7:0] B_LF    = 8'd10;
  localparam logic [7:0] B_SPACE = 8'd32;

  localparam logic [0:0] KIND_BYTE  = 1'b0;
  localparam logic [0:0] KIND_TABLE = 1'b1;

  localparam logic [0:0] CFG_RAW_MODE = 1'b0;
  localparam logic [0:0] CFG_SUPPRESS = 1'b1;

  typedef struct packed {
    logic       emit;
    logic       use_table;
    logic       has_char;
    logic       eol;
    logic [7:0] len;
    logic       trunc;
  } parse_res_t;

endpackage

// ===== sv/tlrp_parse.sv =====
// ----------------------------------------------------------------------------
// tlrp_parse: telnet command stripper and line state
// Holds the command parsing mode, the option skip flag, the character
// count and the overflow flag of the current line, and decides per byte
// whether a result is produced.
// ----------------------------------------------------------------------------
module tlrp_parse #(
  parameter int LINE_CAPACITY = tlrp_pkg::LINE_CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_en,
  input  logic [7:0]            rx_byte,
  input  logic                  raw_mode,
  input  logic                  suppress_empty,
  output tlrp_pkg::parse_res_t  res
);
  import tlrp_pkg::*;

  localparam int CNT_W = $clog2(LINE_CAPACITY);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_CAPACITY - 1);

  localparam logic [2:0] M_NORMAL    = 3'd0;
  localparam logic [2:0] M_AFTER_IAC = 3'd1;
  localparam logic [2:0] M_IN_SB     = 3'd2;
  localparam logic [2:0] M_EAT_CR    = 3'd3;
  localparam logic [2:0] M_EAT_LF    = 3'd4;

  logic [2:0]       mode_r, mode_nxt;
  logic             skip_r, skip_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;

  logic             do_store;
  logic             do_plain;
  logic             is_eol_byte;
  logic [CNT_W+7:0] cnt_ext;

  assign is_eol_byte = (rx_byte == B_CR) || (rx_byte == B_LF);
  assign cnt_ext     = (CNT_W + 8)'(cnt_r);

  always_comb begin
    mode_nxt = mode_r;
    skip_nxt = skip_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    do_store = 1'b0;
    do_plain = 1'b0;
    res      = '0;
    if (skip_r) begin
      skip_nxt = 1'b0;
    end else begin
      case (mode_r)
        M_IN_SB: begin
          if (rx_byte == B_SE) begin
            mode_nxt = M_NORMAL;
          end
        end
        M_AFTER_IAC: begin
          mode_nxt = M_NORMAL;
          if (rx_byte inside {[B_WILL:B_DONT]}) begin
            skip_nxt = 1'b1;
          end else if (rx_byte == B_SB) begin
            mode_nxt = M_IN_SB;
          end else if (rx_byte == B_IAC) begin
            do_store = 1'b1;
          end
        end
        M_EAT_CR: begin
          mode_nxt = M_NORMAL;
          do_plain = (rx_byte != B_CR);
        end
        M_EAT_LF: begin
          mode_nxt = M_NORMAL;
          do_plain = (rx_byte != B_LF);
        end
        default: begin
          mode_nxt = M_NORMAL;
          do_plain = 1'b1;
        end
      endcase
    end

    if (do_plain) begin
      if ((cnt_r == '0) && suppress_empty && is_eol_byte) begin
        mode_nxt = M_NORMAL;
      end else if ((rx_byte == B_IAC) && !raw_mode) begin
        mode_nxt = M_AFTER_IAC;
      end else if (is_eol_byte) begin
        mode_nxt      = (rx_byte == B_CR) ? M_EAT_LF : M_EAT_CR;
        res.emit      = 1'b1;
        res.eol       = 1'b1;
        res.trunc     = ovf_r;
        if (cnt_r == '0) begin
          res.has_char = 1'b1;
          res.len      = 8'd1;
        end else if (cnt_ext > (CNT_W + 8)'(255)) begin
          res.len = 8'hFF;
        end else begin
          res.len = cnt_ext[7:0];
        end
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        do_store = 1'b1;
      end
    end

    if (do_store) begin
      if (cnt_r < CNT_MAX) begin
        cnt_nxt       = cnt_r + 1'b1;
        res.emit      = 1'b1;
        res.use_table = 1'b1;
        res.has_char  = 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (!byte_en) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      skip_r <= 1'b0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (byte_en) begin
      mode_r <= mode_nxt;
      skip_r <= skip_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

// ===== sv/telnet_rx_line_parser.sv =====
// ----------------------------------------------------------------------------
// telnet_rx_line_parser: telnet receive line assembler
// Accepts one transaction per clock cycle while the output is not stalled,
// received bytes and translation table writes alike. Under back-pressure
// the pipeline stage and output register hold, and the input is refused
// once both are full. An accepted byte loads the pipeline stage with the
// registered read of the 256-entry translation memory; the output register
// loads from the stage once it is empty or its result is taken. Telnet
// commands are stripped, data bytes are translated and passed on, and CR
// or LF closes the line with its length and a truncation flag. The table
// has no reset and must be loaded before the bytes that use it arrive.
// ----------------------------------------------------------------------------
module telnet_rx_line_parser #(
  parameter int LINE_CAPACITY = tlrp_pkg::LINE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Fields from bit 0: rx_byte[7:0], table_index[15:8], table_value[23:16].
  input  logic [23:0] in_tdata,
  // Fields from bit 0: kind.
  input  logic [0:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: char_out[7:0], line_length[15:8], truncated[16].
  output logic [23:0] out_tdata,
  // Fields from bit 0: has_char.
  output logic [0:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [0:0]  cfg_wdata
);
  import tlrp_pkg::*;

  logic       raw_mode_r;
  logic       suppress_r;

  logic [7:0] tbl_mem [256];
  logic [7:0] rd_data_r;

  logic       accept;
  logic       byte_en;
  logic       tbl_we;
  parse_res_t res;

  logic       s1_v_r;
  parse_res_t s1_res_r;
  logic       s1_go;

  logic [7:0] char_sel;
  logic [7:0] out_char_r;
  logic [7:0] out_len_r;
  logic       out_trunc_r;
  logic       out_has_r;
  logic       out_eol_r;
  logic       out_v_r;

  assign s1_go     = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_go;
  assign accept    = in_tvalid && in_tready;
  assign byte_en   = accept && (in_tuser == KIND_BYTE);
  assign tbl_we    = accept && (in_tuser == KIND_TABLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r <= 1'b0;
      suppress_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RAW_MODE: raw_mode_r <= cfg_wdata[0];
        CFG_SUPPRESS: suppress_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[in_tdata[15:8]] <= in_tdata[23:16];
    end
    if (byte_en) begin
      rd_data_r <= tbl_mem[in_tdata[7:0]];
    end
  end

  tlrp_parse #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_en       (byte_en),
    .rx_byte       (in_tdata[7:0]),
    .raw_mode      (raw_mode_r),
    .suppress_empty(suppress_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= res.emit;
    end
    if (in_tready) begin
      s1_res_r <= res;
    end
  end

  always_comb begin
    if (s1_res_r.use_table) begin
      char_sel = rd_data_r;
    end else if (s1_res_r.has_char) begin
      char_sel = B_SPACE;
    end else begin
      char_sel = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= s1_v_r;
    end
    if (s1_go) begin
      out_char_r  <= char_sel;
      out_len_r   <= s1_res_r.len;
      out_trunc_r <= s1_res_r.trunc;
      out_has_r   <= s1_res_r.has_char;
      out_eol_r   <= s1_res_r.eol;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_trunc_r, out_len_r, out_char_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_eol_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_go |=> s1_v_r && $stable(rd_data_r) && $stable(s1_res_r))
    else $error("stalled pipeline stage lost its result or table data");

  a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] || out_tlast))
    else $error("result carries neither a character nor a line end");

  a_len_only_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tdata[16:8] == 9'd0))
    else $error("length or truncation reported outside a line end");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_tready)
    else $error("input refused while the pipeline stage is empty");

endmodule
